[sv/lsb_stego_payload_extractor_assert.svh]
// Assertion macros for the pixel payload extractor.
// Expects signals named clk and rst_n in the including module.
`ifndef LSB_STEGO_PAYLOAD_EXTRACTOR_ASSERT_SVH
`define LSB_STEGO_PAYLOAD_EXTRACTOR_ASSERT_SVH

// Property that must hold in the same cycle as its trigger.
`define LSPE_ASSERT_NOW(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
    else $error(msg);

// Property that must hold in the cycle after its trigger.
`define LSPE_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

[sv/lspe_pkg.sv]
// Shared constants and types of the pixel payload extractor.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lspe_pkg;

  // Field widths
  localparam int unsigned PIX_IDX_BITS = 26;
  localparam int unsigned CFG_BITS     = 26;
  localparam int unsigned PIXEL_BITS   = 32;
  localparam int unsigned BYTE_BITS    = 8;
  localparam int unsigned STATUS_BITS  = 3;

  // Image layout, in pixels
  localparam int unsigned SMALL_LIMIT = 80;
  localparam int unsigned SIZE_START  = 8;
  localparam int unsigned SIZE_PIXELS = 11;
  localparam int unsigned SIG_START   = 20;
  localparam int unsigned DATA_START  = 36;
  localparam int unsigned TAIL_CHECK  = 20;

  localparam logic [47:0] SIG_VALUE = 48'h6E616D786F46;
  localparam logic [15:0] ADLER_MOD = 16'd65521;

  typedef logic [PIX_IDX_BITS-1:0] pix_idx_t;
  typedef logic [STATUS_BITS-1:0]  status_t;

  // Status codes
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_TOO_SMALL = 3'd1;
  localparam status_t ST_BAD_SIZE  = 3'd2;
  localparam status_t ST_BAD_SIG   = 3'd3;
  localparam status_t ST_BAD_CHECK = 3'd4;

  // Result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

endpackage

`default_nettype wire

[sv/lspe_pixel_if.sv]
// Pixel input channel: valid/ready handshake carrying one ARGB32 pixel a beat.
// Depends on lspe_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lspe_pixel_if
  import lspe_pkg::*;
  ;
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink   (input valid, input pixel_word, output ready);
endinterface

`default_nettype wire

[sv/lspe_result_if.sv]
// Result channel: valid/ready handshake carrying a payload byte or a status a beat.
// Depends on lspe_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lspe_result_if
  import lspe_pkg::*;
  ;
  logic                 valid;
  logic                 ready;
  logic                 result_kind;
  logic [BYTE_BITS-1:0] payload_byte;
  status_t              status;

  modport source (output valid, output result_kind, output payload_byte, output status,
                  input ready);
  modport sink   (input valid, input result_kind, input payload_byte, input status,
                  output ready);
endinterface

`default_nettype wire

[sv/lspe_cfg_if.sv]
// Configuration write channel: valid/ready handshake carrying the pixel count.
// Depends on lspe_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lspe_cfg_if
  import lspe_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] pixel_count;

  modport source (output valid, output pixel_count, input ready);
  modport sink   (input valid, input pixel_count, output ready);
endinterface

`default_nettype wire

[sv/lsb_stego_payload_extractor.sv]
// Top level of the pixel payload extractor: header parsing, payload bytes, Adler-32 check.
// Depends on lspe_pkg, the three channel interfaces and the assertion macro header.
//
// Usage:
//   cfg_wr carries the image size in pixels (width times height); write it while idle.
//   A count of zero makes the block drop pixels without effect.
//   in_pix takes ARGB32 pixels in raster order, one beat per pixel.
//   out_res gives a payload byte (result_kind 0) whenever the hidden bits complete
//   one, and a status beat (result_kind 1) on the last pixel of each image, after
//   which the block starts over for the next image.
//   A pixel is accepted into an input register; when the output register can take a
//   result it is decoded and its result, if any, lands in the output register.
//   Throughput is one pixel per cycle while out_res keeps up: the input register and
//   the output register each hold one beat.
//   If out_res is stalled with a result waiting, the next pixel waits undecoded in
//   the input register and in_pix.ready drops until the result is taken.
//   Synchronous reset clears the pixel count to zero, the image state and both
//   holding registers.
`timescale 1ns / 1ps
`default_nettype none

`include "lsb_stego_payload_extractor_assert.svh"

module lsb_stego_payload_extractor
  import lspe_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  lspe_cfg_if.sink             cfg_wr,
  lspe_pixel_if.sink           in_pix,
  lspe_result_if.source        out_res
);

  // Registers
  logic [CFG_BITS-1:0]   cnt_r;
  logic                  s1_valid_r;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  pix_idx_t              idx_r,  idx_nxt;
  logic [47:0]           gs_r,   gs_nxt;
  logic [31:0]           psize_r, psize_nxt;
  logic [28:0]           dbc_r,  dbc_nxt;
  logic [7:0]            asmb_r, asmb_nxt;
  logic [15:0]           alo_r,  alo_nxt;
  logic [15:0]           ahi_r,  ahi_nxt;
  logic [31:0]           chk_r,  chk_nxt;
  status_t               err_r,  err_nxt;
  logic                  out_valid_r;
  logic                  out_kind_r;
  logic [7:0]            out_byte_r;
  status_t               out_status_r;

  // Decode signals
  logic                  s2_go;
  logic                  is_last;
  logic                  is_big;
  logic                  emit;
  logic [7:0]            emit_byte;
  status_t               last_status;
  logic [2:0]            hb;
  logic                  in_size, in_sig, in_tail;
  pix_idx_t              size_off, sig_off, tail_base, tail_off;
  pix_idx_t              cap_base;
  logic [27:0]           cap;
  logic [34:0]           total;
  logic [2:0]            take;
  logic [16:0]           lo_sum, hi_sum;
  logic [15:0]           lo_mod;

  // Places the three hidden bits of one pixel into a gathered field.
  function automatic logic [47:0] gather_bits(input logic [47:0] cur, input logic [3:0] rel,
                                              input logic [2:0] bits, input logic [5:0] nbits);
    logic [47:0] res;
    logic [5:0]  k;
    res = (rel == 4'd0) ? 48'd0 : cur;
    for (int c = 0; c < 3; c++) begin
      k = {1'b0, rel, 1'b0} + {2'b0, rel} + 6'(c);
      if (k < nbits) begin
        res[k] = res[k] | bits[c];
      end
    end
    return res;
  endfunction

  // Handshakes: the decode step runs when the output register can take a result.
  assign s2_go        = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_pix.ready = !s1_valid_r || s2_go;
  assign cfg_wr.ready = 1'b1;

  assign out_res.valid        = out_valid_r;
  assign out_res.result_kind  = out_kind_r;
  assign out_res.payload_byte = out_byte_r;
  assign out_res.status       = out_status_r;

  // Window decoding on the pixel index
  assign hb        = {s1_pix_r[16], s1_pix_r[8], s1_pix_r[0]};
  assign is_last   = (cnt_r != '0) && (idx_r >= cnt_r - 1'b1);
  assign is_big    = cnt_r >= CFG_BITS'(SMALL_LIMIT);
  assign size_off  = idx_r - PIX_IDX_BITS'(SIZE_START);
  assign sig_off   = idx_r - PIX_IDX_BITS'(SIG_START);
  assign tail_base = cnt_r - PIX_IDX_BITS'(TAIL_CHECK);
  assign tail_off  = idx_r - tail_base;
  assign in_size   = (idx_r >= PIX_IDX_BITS'(SIZE_START)) &&
                     (idx_r <  PIX_IDX_BITS'(SIZE_START + SIZE_PIXELS));
  assign in_sig    = (idx_r >= PIX_IDX_BITS'(SIG_START)) &&
                     (idx_r <  PIX_IDX_BITS'(DATA_START));
  assign in_tail   = (idx_r >= tail_base) && (tail_off < PIX_IDX_BITS'(SIZE_PIXELS));

  // Payload capacity in bits: three per pixel beyond the reserved ones
  assign cap_base = cnt_r - PIX_IDX_BITS'(SMALL_LIMIT);
  assign cap      = {2'b0, cap_base} + {1'b0, cap_base, 1'b0};
  assign total    = {psize_r, 3'b000};

  // Which of the three hidden bits still belong to the payload
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      take[c] = ({6'd0, dbc_r} + 35'(c)) < total;
    end
  end

  // Final status of the image
  always_comb begin
    if (!is_big) begin
      last_status = ST_TOO_SMALL;
    end else if (err_r == ST_OK && {ahi_r, alo_r} != chk_r) begin
      last_status = ST_BAD_CHECK;
    end else begin
      last_status = err_r;
    end
  end

  // Header fields, stored checksum and payload bit assembly
  always_comb begin
    gs_nxt    = gs_r;
    psize_nxt = psize_r;
    err_nxt   = err_r;
    chk_nxt   = chk_r;
    dbc_nxt   = dbc_r;
    asmb_nxt  = asmb_r;
    emit      = 1'b0;
    emit_byte = 8'd0;
    if (is_big && !is_last) begin
      if (in_size) begin
        gs_nxt = gather_bits(gs_nxt, size_off[3:0], hb, 6'd32);
        if (size_off[3:0] == 4'(SIZE_PIXELS - 1)) begin
          psize_nxt = gs_nxt[31:0];
          if (gs_nxt[31:0] == 32'd0 || gs_nxt[31] ||
              {gs_nxt[31:0], 3'b000} > {7'd0, cap}) begin
            err_nxt = ST_BAD_SIZE;
          end
        end
      end else if (in_sig) begin
        gs_nxt = gather_bits(gs_nxt, sig_off[3:0], hb, 6'd48);
        if (sig_off[3:0] == 4'(DATA_START - SIG_START - 1) && err_nxt == ST_OK &&
            gs_nxt != SIG_VALUE) begin
          err_nxt = ST_BAD_SIG;
        end
      end
      if (in_tail) begin
        gs_nxt = gather_bits(gs_nxt, tail_off[3:0], hb, 6'd32);
        if (tail_off[3:0] == 4'(SIZE_PIXELS - 1)) begin
          chk_nxt = gs_nxt[31:0];
        end
      end
      // At most one byte completes per pixel
      if (idx_r >= PIX_IDX_BITS'(DATA_START) && err_r == ST_OK) begin
        for (int c = 0; c < 3; c++) begin
          if (take[c]) begin
            asmb_nxt[dbc_nxt[2:0]] = asmb_nxt[dbc_nxt[2:0]] | hb[c];
            dbc_nxt = dbc_nxt + 29'd1;
            if (dbc_nxt[2:0] == 3'd0) begin
              emit      = 1'b1;
              emit_byte = asmb_nxt;
              asmb_nxt  = 8'd0;
            end
          end
        end
      end
    end
  end

  // Adler-32 update with one byte
  assign lo_sum = {1'b0, alo_r} + {9'd0, emit_byte};
  assign lo_mod = (lo_sum >= {1'b0, ADLER_MOD}) ? 16'(lo_sum - {1'b0, ADLER_MOD})
                                                : lo_sum[15:0];
  assign hi_sum = {1'b0, ahi_r} + {1'b0, lo_mod};

  always_comb begin
    alo_nxt = alo_r;
    ahi_nxt = ahi_r;
    if (emit) begin
      alo_nxt = lo_mod;
      ahi_nxt = (hi_sum >= {1'b0, ADLER_MOD}) ? 16'(hi_sum - {1'b0, ADLER_MOD})
                                              : hi_sum[15:0];
    end
  end

  // Pixel index: held while the count is zero, cleared on the last pixel
  always_comb begin
    if (cnt_r == '0) begin
      idx_nxt = idx_r;
    end else if (is_last) begin
      idx_nxt = '0;
    end else begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      cnt_r <= cfg_wr.pixel_count;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_pix.ready) begin
      s1_valid_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pix.valid && in_pix.ready) begin
      s1_pix_r <= in_pix.pixel_word;
    end
  end

  // Image state, restarted after the last pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      gs_r    <= '0;
      psize_r <= '0;
      dbc_r   <= '0;
      asmb_r  <= '0;
      alo_r   <= 16'd1;
      ahi_r   <= '0;
      chk_r   <= '0;
      err_r   <= ST_OK;
    end else if (s2_go && is_last) begin
      idx_r   <= '0;
      gs_r    <= '0;
      psize_r <= '0;
      dbc_r   <= '0;
      asmb_r  <= '0;
      alo_r   <= 16'd1;
      ahi_r   <= '0;
      chk_r   <= '0;
      err_r   <= ST_OK;
    end else if (s2_go) begin
      idx_r   <= idx_nxt;
      gs_r    <= gs_nxt;
      psize_r <= psize_nxt;
      dbc_r   <= dbc_nxt;
      asmb_r  <= asmb_nxt;
      alo_r   <= alo_nxt;
      ahi_r   <= ahi_nxt;
      chk_r   <= chk_nxt;
      err_r   <= err_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go && (is_last || emit)) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && is_last) begin
      out_kind_r   <= KIND_STATUS;
      out_byte_r   <= 8'd0;
      out_status_r <= last_status;
    end else if (s2_go && emit) begin
      out_kind_r   <= KIND_BYTE;
      out_byte_r   <= emit_byte;
      out_status_r <= ST_OK;
    end
  end

  // Checks
  `LSPE_ASSERT_NOW(a_adler_in_range, 1'b1, (alo_r < ADLER_MOD) && (ahi_r < ADLER_MOD), "Adler-32 sum out of range")
  `LSPE_ASSERT_NOW(a_no_byte_after_error, s2_go && emit, err_r == ST_OK, "payload byte given after a header failure")
  `LSPE_ASSERT_NEXT(a_restart_after_last, s2_go && is_last, (idx_r == '0) && (alo_r == 16'd1) && (err_r == ST_OK), "image state not restarted after the last pixel")
  `LSPE_ASSERT_NOW(a_error_codes, 1'b1, (err_r == ST_OK) || (err_r == ST_BAD_SIZE) || (err_r == ST_BAD_SIG), "unexpected header error code")

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the LSB payload extractor: directed images from a table,
// then random images, all results checked against a cycle-free predictor of the block.
// Depends on lspe_pkg, the three channel interfaces and the extractor top level.
`timescale 1ns / 1ps

module tb_top;
  import lspe_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_PIXELS = 800;
  localparam int unsigned DRAIN_CYCLES  = 4;
  localparam int unsigned MAX_REPORTS   = 10;

  // Ways of filling an image: plain patterns or a header-framed payload with faults.
  typedef enum {
    FILL_ZERO, FILL_ONES, FILL_RAND,
    IMG_GOOD, IMG_SIZE_FULL, IMG_ALL_FF, IMG_SIZE_ZERO, IMG_SIZE_NEG,
    IMG_SIZE_OVER, IMG_BAD_SIG, IMG_BAD_CHECK, IMG_TWO_FAULTS
  } fill_t;

  // Receiver back-pressure patterns.
  typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_pat_t;

  typedef struct packed {
    logic                 kind;
    logic [BYTE_BITS-1:0] data;
    status_t              st;
  } res_beat_t;

  typedef struct {
    logic [CFG_BITS-1:0] count;
    fill_t               fill;
    int unsigned         npix;
    bit                  typed;
    status_t             st;
  } dir_row_t;

  logic clk;
  logic rst_n;

  lspe_cfg_if    cfg_bus ();
  lspe_pixel_if  pix_bus ();
  lspe_result_if res_bus ();

  lsb_stego_payload_extractor i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_bus),
    .in_pix  (pix_bus),
    .out_res (res_bus)
  );

  // Predicted image state of the block.
  logic [CFG_BITS-1:0] m_count;
  pix_idx_t            m_idx;
  logic [47:0]         m_gather;
  logic [31:0]         m_size;
  logic [28:0]         m_bits;
  logic [7:0]          m_asm;
  logic [15:0]         m_lo;
  logic [15:0]         m_hi;
  logic [31:0]         m_stored;
  status_t             m_err;

  res_beat_t pending_results [$];
  int        mismatches;
  bit        saw_status;
  status_t   last_status;

  // Image generator state.
  fill_t       g_fill;
  int unsigned g_count;
  logic [31:0] g_size;
  logic [47:0] g_sig;
  logic [31:0] g_check;
  logic [7:0]  g_pay [$];
  int unsigned burst_left;

  rx_pat_t     rx_mode;
  int unsigned rx_cyc;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic void restart_image();
    m_idx    = '0;
    m_gather = '0;
    m_size   = '0;
    m_bits   = '0;
    m_asm    = '0;
    m_lo     = 16'd1;
    m_hi     = '0;
    m_stored = '0;
    m_err    = ST_OK;
  endfunction

  // Collects the three hidden bits of one pixel into a field of nbits bits.
  function automatic void gather_bits(logic [31:0] w, int unsigned rel, int unsigned nbits);
    int unsigned k;
    int c;
    if (rel == 0) m_gather = '0;
    for (c = 0; c < 3; c++) begin
      k = rel * 3 + c;
      if (k < nbits) m_gather[k] = m_gather[k] | w[8*c];
    end
  endfunction

  // Works out what one accepted pixel causes and queues the result, if any.
  function automatic void predict_pixel(logic [31:0] w);
    int unsigned     cnt;
    int unsigned     p;
    longint unsigned cap;
    longint unsigned total;
    logic [16:0]     sum;
    status_t         st;
    int              c;
    cnt = m_count;
    p   = m_idx;
    if (cnt == 0) return;

    // Last pixel of the image, or beyond it after a count change: status only.
    if (p >= cnt - 1) begin
      if (cnt < SMALL_LIMIT) st = ST_TOO_SMALL;
      else begin
        st = m_err;
        if (st == ST_OK && {m_hi, m_lo} != m_stored) st = ST_BAD_CHECK;
      end
      pending_results.push_back('{KIND_STATUS, 8'd0, st});
      restart_image();
      return;
    end

    if (cnt >= SMALL_LIMIT) begin
      // Header fields: payload size, then signature.
      if (p >= SIZE_START && p < SIZE_START + SIZE_PIXELS) begin
        gather_bits(w, p - SIZE_START, 32);
        if (p == SIZE_START + SIZE_PIXELS - 1) begin
          m_size = m_gather[31:0];
          cap = longint'(cnt - SMALL_LIMIT) * 3;
          if (m_size == 0 || m_size[31] || longint'(m_size) * 8 > cap) m_err = ST_BAD_SIZE;
        end
      end else if (p >= SIG_START && p < DATA_START) begin
        gather_bits(w, p - SIG_START, 48);
        if (p == DATA_START - 1 && m_err == ST_OK && m_gather != SIG_VALUE) m_err = ST_BAD_SIG;
      end

      // Stored checksum near the end of the image.
      if (p >= cnt - TAIL_CHECK && p < cnt - TAIL_CHECK + 11) begin
        gather_bits(w, p - (cnt - TAIL_CHECK), 32);
        if (p == cnt - TAIL_CHECK + 10) m_stored = m_gather[31:0];
      end

      // Payload bits, LSB first, with a running Adler-32 per completed byte.
      if (p >= DATA_START && m_err == ST_OK) begin
        total = longint'(m_size) * 8;
        for (c = 0; c < 3; c++) begin
          if (longint'(m_bits) >= total) break;
          m_asm[m_bits[2:0]] = m_asm[m_bits[2:0]] | w[8*c];
          m_bits = m_bits + 1'b1;
          if (m_bits[2:0] == 3'd0) begin
            sum = {1'b0, m_lo} + m_asm;
            if (sum >= ADLER_MOD) sum = sum - ADLER_MOD;
            m_lo = sum[15:0];
            sum = {1'b0, m_hi} + m_lo;
            if (sum >= ADLER_MOD) sum = sum - ADLER_MOD;
            m_hi = sum[15:0];
            pending_results.push_back('{KIND_BYTE, m_asm, ST_OK});
            m_asm = '0;
          end
        end
      end
    end
    m_idx = pix_idx_t'(p + 1);
  endfunction

  // Compares one result beat with the oldest expectation.
  function automatic void check_result();
    res_beat_t got;
    res_beat_t want;
    got = '{res_bus.result_kind, res_bus.payload_byte, res_bus.status};
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result: kind %0d byte %02h status %0d",
                                got.kind, got.data, got.st));
    end else begin
      want = pending_results.pop_front();
      if (got.kind != want.kind || got.data != want.data || got.st != want.st)
        report_mismatch($sformatf("result mismatch: expected kind %0d byte %02h status %0d, got kind %0d byte %02h status %0d",
                                  want.kind, want.data, want.st, got.kind, got.data, got.st));
    end
    if (got.kind == KIND_STATUS) begin
      saw_status  = 1'b1;
      last_status = got.st;
    end
  endfunction

  // Watches every handshake at the edge it completes on.
  always @(posedge clk) begin
    if (!rst_n) begin
      m_count = '0;
      restart_image();
    end else begin
      if (res_bus.valid && res_bus.ready) check_result();
      if (cfg_bus.valid && cfg_bus.ready) m_count = cfg_bus.pixel_count;
      if (pix_bus.valid && pix_bus.ready) predict_pixel(pix_bus.pixel_word);
    end
  end

  // Receiver stalls on a pattern that changes now and then.
  always @(posedge clk) begin
    rx_cyc++;
    if (rx_cyc % 97 == 0) rx_mode = rx_pat_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   res_bus.ready <= 1'b1;
      RX_MOSTLY: res_bus.ready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: res_bus.ready <= ($urandom_range(0, 3) == 0);
      default:   res_bus.ready <= (rx_cyc % 5 != 0);
    endcase
  end

  // Prepares the header fields and payload of the next image.
  task automatic setup_image(input int unsigned cnt, input fill_t fill);
    int unsigned cap_bytes;
    int unsigned nbytes;
    int unsigned k;
    int unsigned a;
    int unsigned b;
    g_fill    = fill;
    g_count   = cnt;
    cap_bytes = (cnt >= SMALL_LIMIT) ? (cnt - SMALL_LIMIT) * 3 / 8 : 0;
    if (fill == IMG_SIZE_FULL || fill == IMG_ALL_FF) nbytes = cap_bytes;
    else if (cap_bytes == 0) nbytes = 1;
    else nbytes = $urandom_range(1, (cap_bytes > 40) ? 40 : cap_bytes);

    g_pay.delete();
    a = 1;
    b = 0;
    for (k = 0; k < nbytes; k++) begin
      g_pay.push_back((fill == IMG_ALL_FF) ? 8'hFF : 8'($urandom));
      a = (a + g_pay[k]) % ADLER_MOD;
      b = (b + a) % ADLER_MOD;
    end
    g_check = {b[15:0], a[15:0]};
    g_size  = nbytes;
    g_sig   = SIG_VALUE;

    case (fill)
      IMG_SIZE_ZERO:  g_size = '0;
      IMG_SIZE_NEG:   g_size = {1'b1, 31'($urandom)};
      IMG_SIZE_OVER:  g_size = cap_bytes + 1;
      IMG_BAD_SIG:    g_sig[$urandom_range(0, 47)] ^= 1'b1;
      IMG_BAD_CHECK:  g_check[$urandom_range(0, 31)] ^= 1'b1;
      IMG_TWO_FAULTS: begin
        g_size = '0;
        g_sig[$urandom_range(0, 47)] ^= 1'b1;
      end
      default: ;
    endcase
  endtask

  // Pixel p of the current image: random colour with the hidden bits put in place.
  function automatic logic [31:0] image_word(int unsigned p);
    logic [31:0] w;
    int unsigned k;
    int          c;
    w = $urandom;
    case (g_fill)
      FILL_ZERO: return '0;
      FILL_ONES: return '1;
      FILL_RAND: return w;
      default: ;
    endcase
    for (c = 0; c < 3; c++) begin
      if (p >= SIZE_START && p < SIZE_START + SIZE_PIXELS) begin
        k = (p - SIZE_START) * 3 + c;
        if (k < 32) w[8*c] = g_size[k];
      end else if (p >= SIG_START && p < DATA_START) begin
        w[8*c] = g_sig[(p - SIG_START) * 3 + c];
      end else if (p >= g_count - TAIL_CHECK && p < g_count - TAIL_CHECK + 11) begin
        k = (p - (g_count - TAIL_CHECK)) * 3 + c;
        if (k < 32) w[8*c] = g_check[k];
      end else if (p >= DATA_START) begin
        k = (p - DATA_START) * 3 + c;
        if (k < 8 * g_pay.size()) w[8*c] = g_pay[k / 8][k % 8];
      end
    end
    return w;
  endfunction

  task automatic write_count(input logic [CFG_BITS-1:0] v);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.pixel_count <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  // Offers one pixel and holds it until the beat is taken; valid stays high.
  task automatic send_pixel(input logic [31:0] w);
    pix_bus.valid      <= 1'b1;
    pix_bus.pixel_word <= w;
    do @(posedge clk); while (!pix_bus.ready);
  endtask

  // Sends the first n pixels of the current image in bursts with random gaps.
  task automatic send_image(input int unsigned n);
    int unsigned p;
    int unsigned gap;
    for (p = 0; p < n; p++) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          pix_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 60);
      end
      burst_left--;
      send_pixel(image_word(p));
    end
  endtask

  // Stops sending until every expected result is in, then lets the pipeline empty.
  task automatic settle();
    pix_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    dir_row_t    dir_rows [17];
    int unsigned sent;
    int unsigned cnt;
    int unsigned npix;
    int unsigned pick;
    fill_t       fill;
    int          i;

    rst_n               = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.pixel_count = '0;
    pix_bus.valid       = 1'b0;
    pix_bus.pixel_word  = '0;
    res_bus.ready       = 1'b0;
    rx_mode             = RX_OPEN;
    rx_cyc              = 0;
    burst_left          = 0;
    mismatches          = 0;
    saw_status          = 1'b0;
    last_status         = ST_OK;

    // Directed images; a typed status is checked where it is obvious.
    dir_rows = '{
      '{26'd0,         FILL_RAND,      3,   1'b0, ST_OK},        // empty image, ignored
      '{26'd1,         FILL_ONES,      2,   1'b1, ST_TOO_SMALL}, // every pixel is the last
      '{26'd2,         FILL_ZERO,      2,   1'b1, ST_TOO_SMALL},
      '{26'd79,        FILL_ONES,      79,  1'b1, ST_TOO_SMALL}, // just below the header size
      '{26'd80,        IMG_SIZE_OVER,  80,  1'b1, ST_BAD_SIZE},  // no room at all
      '{26'd120,       IMG_GOOD,       120, 1'b1, ST_OK},
      '{26'd120,       IMG_SIZE_FULL,  120, 1'b1, ST_OK},        // payload fills capacity
      '{26'd100,       IMG_SIZE_ZERO,  100, 1'b1, ST_BAD_SIZE},
      '{26'd100,       IMG_SIZE_NEG,   100, 1'b1, ST_BAD_SIZE},
      '{26'd100,       IMG_BAD_SIG,    100, 1'b1, ST_BAD_SIG},
      '{26'd100,       IMG_BAD_CHECK,  100, 1'b1, ST_BAD_CHECK},
      '{26'd100,       IMG_TWO_FAULTS, 100, 1'b1, ST_BAD_SIZE},  // first failure wins
      '{26'd780,       IMG_ALL_FF,     780, 1'b1, ST_OK},        // both Adler sums wrap
      '{26'h3FFFFFF,   IMG_GOOD,       45,  1'b0, ST_OK},        // largest count, cut short
      '{26'd30,        FILL_RAND,      1,   1'b1, ST_TOO_SMALL}, // count shrunk mid-image
      '{26'd90,        FILL_RAND,      90,  1'b0, ST_OK},
      '{26'd90,        FILL_ZERO,      90,  1'b1, ST_BAD_SIZE}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 17; i++) begin
      write_count(dir_rows[i].count);
      setup_image(dir_rows[i].count, dir_rows[i].fill);
      saw_status = 1'b0;
      send_image(dir_rows[i].npix);
      settle();
      if (dir_rows[i].typed && (!saw_status || last_status != dir_rows[i].st))
        report_mismatch($sformatf("image %0d: expected status %0d, got %0d (seen %0d)",
                                  i, dir_rows[i].st, last_status, saw_status));
    end

    // Random images, mostly well framed, some faulty, noisy or cut short.
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 19);
      cnt  = $urandom_range(80, (pick == 19) ? 250 : 120);
      fill = IMG_GOOD;
      case (pick)
        0: begin
          cnt  = 0;
          fill = FILL_RAND;
        end
        1, 2: begin
          cnt  = $urandom_range(1, 79);
          fill = fill_t'($urandom_range(FILL_ZERO, FILL_RAND));
        end
        3: fill = FILL_RAND;
        5, 6, 7: fill = fill_t'($urandom_range(IMG_SIZE_ZERO, IMG_TWO_FAULTS));
        8: fill = IMG_SIZE_FULL;
        default: ;
      endcase
      npix = (cnt == 0) ? 3 : (pick == 4) ? $urandom_range(1, cnt - 1) : cnt;
      write_count(cnt);
      setup_image(cnt, fill);
      send_image(npix);
      if (cnt != 0) sent += npix;
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
